/* rtl/core/pcwm_pkg.sv */
// Package of the poll cadence window monitor.
// Holds the shared types, register indexes and reset constants.
// Used by pcwm_front, pcwm_back and the top level; depends on nothing.
package pcwm_pkg;

   localparam int NUM_BUCKETS = 6;
   localparam int NUM_LIMITS  = 5;
   localparam int FRAME_BYTES = 25;
   localparam int FRAME_IDX_W = 5;

   localparam logic [2:0] REG_WINDOW_TICKS = 3'd0;
   localparam logic [2:0] REG_GAP_A        = 3'd1;
   localparam logic [2:0] REG_GAP_B        = 3'd2;
   localparam logic [2:0] REG_GAP_C        = 3'd3;
   localparam logic [2:0] REG_GAP_D        = 3'd4;
   localparam logic [2:0] REG_GAP_E        = 3'd5;

   localparam logic [31:0] WINDOW_TICKS_RESET = 32'd1000000;
   localparam logic [15:0] GAP_A_RESET        = 16'd1000;
   localparam logic [15:0] GAP_B_RESET        = 16'd1250;
   localparam logic [15:0] GAP_C_RESET        = 16'd1500;
   localparam logic [15:0] GAP_D_RESET        = 16'd2000;
   localparam logic [15:0] GAP_E_RESET        = 16'd5000;
   localparam logic [15:0] COUNT_MAX          = 16'hffff;
   localparam logic [7:0]  NO_WINDOW          = 8'hff;

   localparam logic [1:0] OP_SCAN = 2'd0;
   localparam logic [1:0] OP_POLL = 2'd1;
   localparam logic [1:0] OP_PAGE = 2'd2;

   typedef enum logic [1:0] {
      KIND_SCAN,
      KIND_POLL,
      KIND_PAGE,
      KIND_BAD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] now_ticks;
      logic [7:0]  page_number;
   } job_type;

   typedef struct packed {
      logic [31:0]                  window_ticks;
      logic [NUM_LIMITS-1:0][15:0]  gap_limit;
   } cfg_type;

   typedef struct packed {
      logic [NUM_BUCKETS-1:0][15:0] histogram;
      logic [15:0]                  poll_count;
      logic [15:0]                  scan_count;
      logic [31:0]                  max_gap;
   } window_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIVIDE,
      B_PUSH,
      B_UPDATE,
      B_FETCH,
      B_EMIT
   } back_state_type;

endpackage

/* rtl/core/pcwm_front.sv */
// Front part of the poll cadence window monitor: accepts and classifies items.
// Classified jobs wait in a two-entry queue for the back part. Uses pcwm_pkg.
module pcwm_front import pcwm_pkg::*; #(
   parameter int RING_WINDOWS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ticks[31:0], page_number[39:32]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        job_valid,
   output job_type     job,
   input  logic        job_take
);

   localparam logic [8:0] RING_LIMIT = 9'(RING_WINDOWS);

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   job_type    incoming;

   always_comb begin
      incoming.now_ticks   = req_tdata[31:0];
      incoming.page_number = req_tdata[39:32];
      case (req_tuser)
         OP_SCAN: incoming.kind = KIND_SCAN;
         OP_POLL: incoming.kind = KIND_POLL;
         OP_PAGE: begin
            if ({1'b0, req_tdata[39:32]} > RING_LIMIT) begin
               incoming.kind = KIND_BAD;
            end else begin
               incoming.kind = KIND_PAGE;
            end
         end
         default: incoming.kind = KIND_BAD;
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && (req_tuser != 2'd3);
   assign job_valid  = (count_ff != 2'd0);
   assign job        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ job_take;
      count_in  = count_ff + 2'(push) - 2'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

/* rtl/core/pcwm_back.sv */
// Back part of the poll cadence window monitor: window advance, statistics and pages.
// Holds the ring of completed windows, a serial divider and the output register.
// Uses pcwm_pkg; fed by pcwm_front.
module pcwm_back import pcwm_pkg::*; #(
   parameter int RING_WINDOWS  = 8,
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_take,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   output logic       rsp_tuser
);

   localparam int SW = (RING_WINDOWS > 1) ? $clog2(RING_WINDOWS) : 1;
   localparam int FW = $clog2(RING_WINDOWS + 1);
   localparam int CW = $clog2(PAYLOAD_BYTES);
   localparam logic [31:0] RING_W32 = 32'(RING_WINDOWS);
   localparam logic [8:0]  RING_W9  = 9'(RING_WINDOWS);
   localparam logic [FW-1:0] RING_WF = FW'(RING_WINDOWS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(RING_WINDOWS - 1);
   localparam logic [CW-1:0] LAST_BYTE = CW'(PAYLOAD_BYTES - 1);
   localparam logic [7:0]  PAGE_COUNT = 8'(RING_WINDOWS + 1);

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [31:0]    quot_ff, quot_in;
   logic [31:0]    rem_ff, rem_in;
   logic [4:0]     step_ff, step_in;
   logic [FW-1:0]  push_left_ff, push_left_in;
   window_type     cur_ff, cur_in;
   logic [31:0]    window_start_ff, window_start_in;
   logic [31:0]    prev_poll_ff, prev_poll_in;
   logic [31:0]    seq_ff, seq_in;
   logic [SW-1:0]  next_slot_ff, next_slot_in;
   logic [FW-1:0]  filled_ff, filled_in;
   logic           started_ff, started_in;
   logic           prev_known_ff, prev_known_in;
   logic           win_ok_ff, win_ok_in;
   logic [CW-1:0]  byte_cnt_ff, byte_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_user_ff, rsp_user_in;

   window_type     ring_mem [RING_WINDOWS];
   window_type     ring_q_ff;
   logic           mem_we, mem_re;
   logic [SW-1:0]  mem_ra;

   logic [31:0]    len;
   logic [32:0]    rem_sh;
   logic           rem_ge;
   logic [31:0]    gap;
   logic [2:0]     bucket;
   logic [8:0]     oldest9, slot9;
   logic [7:0]     win_idx;
   logic [7:0]     frame [FRAME_BYTES];
   logic [7:0]     cur_byte;

   always_comb begin
      len    = (cfg.window_ticks == 32'd0) ? 32'd1 : cfg.window_ticks;
      rem_sh = {rem_ff, quot_ff[31]};
      rem_ge = (rem_sh >= {1'b0, len});
      gap    = job_ff.now_ticks - prev_poll_ff;
      if (gap <= {16'd0, cfg.gap_limit[0]}) begin
         bucket = 3'd0;
      end else if (gap <= {16'd0, cfg.gap_limit[1]}) begin
         bucket = 3'd1;
      end else if (gap <= {16'd0, cfg.gap_limit[2]}) begin
         bucket = 3'd2;
      end else if (gap <= {16'd0, cfg.gap_limit[3]}) begin
         bucket = 3'd3;
      end else if (gap <= {16'd0, cfg.gap_limit[4]}) begin
         bucket = 3'd4;
      end else begin
         bucket = 3'd5;
      end
      win_idx = job_ff.page_number - 8'd1;
      oldest9 = 9'(next_slot_ff) + ((9'(next_slot_ff) < 9'(filled_ff)) ? RING_W9 : 9'd0)
                - 9'(filled_ff);
      slot9   = oldest9 + {1'b0, win_idx};
      if (slot9 >= RING_W9) begin
         slot9 = slot9 - RING_W9;
      end
   end

   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         frame[i] = 8'd0;
      end
      if (job_ff.page_number == 8'd0) begin
         frame[0] = 8'd1;
         frame[1] = PAGE_COUNT;
         frame[2] = 8'(filled_ff);
         for (int i = 0; i < 4; i++) begin
            frame[3 + i] = seq_ff[8*i +: 8];
            frame[7 + i] = cfg.window_ticks[8*i +: 8];
         end
         for (int i = 0; i < NUM_LIMITS; i++) begin
            frame[11 + 2*i] = cfg.gap_limit[i][7:0];
            frame[12 + 2*i] = cfg.gap_limit[i][15:8];
         end
         frame[21] = {7'd0, started_ff};
      end else begin
         for (int i = 0; i < 4; i++) begin
            frame[i] = seq_ff[8*i +: 8];
         end
         frame[4] = NO_WINDOW;
         if (win_ok_ff) begin
            frame[4] = win_idx;
            for (int i = 0; i < 4; i++) begin
               frame[5 + i] = ring_q_ff.max_gap[8*i +: 8];
            end
            frame[9]  = ring_q_ff.scan_count[7:0];
            frame[10] = ring_q_ff.scan_count[15:8];
            frame[11] = ring_q_ff.poll_count[7:0];
            frame[12] = ring_q_ff.poll_count[15:8];
            for (int i = 0; i < NUM_BUCKETS; i++) begin
               frame[13 + 2*i] = ring_q_ff.histogram[i][7:0];
               frame[14 + 2*i] = ring_q_ff.histogram[i][15:8];
            end
         end
      end
      if (32'(byte_cnt_ff) < 32'(FRAME_BYTES)) begin
         cur_byte = frame[byte_cnt_ff[FRAME_IDX_W-1:0]];
      end else begin
         cur_byte = 8'd0;
      end
   end

   always_comb begin
      state_in        = state_ff;
      job_in          = job_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      push_left_in    = push_left_ff;
      cur_in          = cur_ff;
      window_start_in = window_start_ff;
      prev_poll_in    = prev_poll_ff;
      seq_in          = seq_ff;
      next_slot_in    = next_slot_ff;
      filled_in       = filled_ff;
      started_in      = started_ff;
      prev_known_in   = prev_known_ff;
      win_ok_in       = win_ok_ff;
      byte_cnt_in     = byte_cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_user_in     = rsp_user_ff;
      job_take        = 1'b0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_ra          = slot9[SW-1:0];

      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_take    = 1'b1;
               job_in      = job;
               byte_cnt_in = '0;
               case (job.kind)
                  KIND_SCAN, KIND_POLL: begin
                     if (!started_ff) begin
                        started_in      = 1'b1;
                        window_start_in = job.now_ticks;
                        state_in        = B_UPDATE;
                     end else begin
                        quot_in  = job.now_ticks - window_start_ff;
                        rem_in   = 32'd0;
                        step_in  = 5'd0;
                        state_in = B_DIVIDE;
                     end
                  end
                  KIND_PAGE: state_in = B_FETCH;
                  default:   state_in = B_EMIT;
               endcase
            end
         end
         B_DIVIDE: begin
            rem_in  = rem_ge ? 32'(rem_sh - {1'b0, len}) : rem_sh[31:0];
            quot_in = {quot_ff[30:0], rem_ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               window_start_in = job_ff.now_ticks - rem_in;
               push_left_in    = (quot_in > RING_W32) ? RING_WF : quot_in[FW-1:0];
               state_in        = (quot_in == 32'd0) ? B_UPDATE : B_PUSH;
            end
         end
         B_PUSH: begin
            mem_we       = 1'b1;
            cur_in       = '0;
            next_slot_in = (next_slot_ff == LAST_SLOT) ? '0 : next_slot_ff + SW'(1);
            filled_in    = (filled_ff == RING_WF) ? filled_ff : filled_ff + FW'(1);
            seq_in       = seq_ff + 32'd1;
            push_left_in = push_left_ff - FW'(1);
            if (push_left_ff == FW'(1)) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            if (job_ff.kind == KIND_SCAN) begin
               if (cur_ff.scan_count != COUNT_MAX) begin
                  cur_in.scan_count = cur_ff.scan_count + 16'd1;
               end
            end else begin
               if (cur_ff.poll_count != COUNT_MAX) begin
                  cur_in.poll_count = cur_ff.poll_count + 16'd1;
               end
               if (prev_known_ff) begin
                  if (gap > cur_ff.max_gap) begin
                     cur_in.max_gap = gap;
                  end
                  if (cur_ff.histogram[bucket] != COUNT_MAX) begin
                     cur_in.histogram[bucket] = cur_ff.histogram[bucket] + 16'd1;
                  end
               end
               prev_poll_in  = job_ff.now_ticks;
               prev_known_in = 1'b1;
            end
            state_in = B_IDLE;
         end
         B_FETCH: begin
            mem_re    = 1'b1;
            win_ok_in = (job_ff.page_number != 8'd0) && (9'(win_idx) < 9'(filled_ff));
            state_in  = B_EMIT;
         end
         B_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (job_ff.kind == KIND_BAD) begin
                  rsp_data_in = 8'd0;
                  rsp_last_in = 1'b1;
                  rsp_user_in = 1'b0;
                  state_in    = B_IDLE;
               end else begin
                  rsp_data_in = cur_byte;
                  rsp_last_in = (byte_cnt_ff == LAST_BYTE);
                  rsp_user_in = 1'b1;
                  byte_cnt_in = byte_cnt_ff + CW'(1);
                  if (byte_cnt_ff == LAST_BYTE) begin
                     state_in = B_IDLE;
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_IDLE;
         cur_ff          <= '0;
         window_start_ff <= 32'd0;
         prev_poll_ff    <= 32'd0;
         seq_ff          <= 32'd0;
         next_slot_ff    <= '0;
         filled_ff       <= '0;
         started_ff      <= 1'b0;
         prev_known_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cur_ff          <= cur_in;
         window_start_ff <= window_start_in;
         prev_poll_ff    <= prev_poll_in;
         seq_ff          <= seq_in;
         next_slot_ff    <= next_slot_in;
         filled_ff       <= filled_in;
         started_ff      <= started_in;
         prev_known_ff   <= prev_known_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      push_left_ff <= push_left_in;
      win_ok_ff    <= win_ok_in;
      byte_cnt_ff  <= byte_cnt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[next_slot_ff] <= cur_ff;
      end
      if (mem_re) begin
         ring_q_ff <= ring_mem[mem_ra];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* rtl/core/poll_cadence_window_monitor_unit.sv */
// Top level of the poll cadence window monitor: register port and the two parts.
// Instantiates pcwm_front and pcwm_back; uses pcwm_pkg.
//
//   Channel | Direction | Carries
//   req_    | in        | scan, poll or page read item
//   rsp_    | out       | page payload bytes
//   csr_    | in/out    | window length and five gap limits
//
// Once taken from the queue, a scan or poll runs the one-bit-a-cycle divider of the
// elapsed time by the window length, pushes ended windows, then updates counts.
// The first event after reset starts the window clock and skips the divider.
// A page read fetches from the ring, then sends its bytes as the sink takes them.
// Reset is synchronous and clears all statistics; a page shows only written windows.
// The two-entry queue accepts items while the back part works or stalls, until full.
module poll_cadence_window_monitor_unit import pcwm_pkg::*; #(
   parameter int RING_WINDOWS  = 8,
   parameter int PAYLOAD_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // now_ticks[31:0], page_number[39:32]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // payload_byte[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // page_valid[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       job_valid;
   job_type    job;
   logic       job_take;
   logic [2:0] reg_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_WINDOW_TICKS: cfg_in.window_ticks = csr_pwdata;
            REG_GAP_A:        cfg_in.gap_limit[0] = csr_pwdata[15:0];
            REG_GAP_B:        cfg_in.gap_limit[1] = csr_pwdata[15:0];
            REG_GAP_C:        cfg_in.gap_limit[2] = csr_pwdata[15:0];
            REG_GAP_D:        cfg_in.gap_limit[3] = csr_pwdata[15:0];
            REG_GAP_E:        cfg_in.gap_limit[4] = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
      case (reg_index)
         REG_WINDOW_TICKS: csr_prdata = cfg_ff.window_ticks;
         REG_GAP_A:        csr_prdata = {16'd0, cfg_ff.gap_limit[0]};
         REG_GAP_B:        csr_prdata = {16'd0, cfg_ff.gap_limit[1]};
         REG_GAP_C:        csr_prdata = {16'd0, cfg_ff.gap_limit[2]};
         REG_GAP_D:        csr_prdata = {16'd0, cfg_ff.gap_limit[3]};
         REG_GAP_E:        csr_prdata = {16'd0, cfg_ff.gap_limit[4]};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks <= WINDOW_TICKS_RESET;
         cfg_ff.gap_limit[0] <= GAP_A_RESET;
         cfg_ff.gap_limit[1] <= GAP_B_RESET;
         cfg_ff.gap_limit[2] <= GAP_C_RESET;
         cfg_ff.gap_limit[3] <= GAP_D_RESET;
         cfg_ff.gap_limit[4] <= GAP_E_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pcwm_front #(
      .RING_WINDOWS(RING_WINDOWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .job_valid  (job_valid),
      .job        (job),
      .job_take   (job_take)
   );

   pcwm_back #(
      .RING_WINDOWS (RING_WINDOWS),
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .job_valid  (job_valid),
      .job        (job),
      .job_take   (job_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/core/pcwm_checker.sv */
// Port-level checks of the poll cadence window monitor.
// Bound to poll_cadence_window_monitor_unit; depends on nothing else.
module pcwm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic       rsp_tuser
);

   a_invalid_page_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("An invalid page result is not a single zero item.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("A stalled result item changed.");

   a_quiet_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("A result item appeared right after reset.");

endmodule

bind poll_cadence_window_monitor_unit pcwm_checker u_pcwm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
